>>> rtl/ole_pkg.sv
// shared constants, codes and types of the ordered list engine
package ole_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int MODE_W   = 3;
  localparam int OIDX_W   = 5;
  localparam int LEN_W    = 6;
  localparam int STAT_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MD_INS_FRONT  = 3'd0,
    MD_INS_BACK   = 3'd1,
    MD_INS_AFTER  = 3'd2,
    MD_INS_BEFORE = 3'd3,
    MD_DEL_FRONT  = 3'd4,
    MD_DEL_BACK   = 3'd5,
    MD_DEL_KEY    = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_EMIT
  } state_t;

  // one read and one write request to the entry store per cycle
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } mem_req_t;

endpackage

>>> rtl/ole_if.sv
// request and result channel interfaces of the ordered list engine
interface ole_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] new_value;
  logic signed [31:0] search_key;

  modport source (output valid, output mode, output new_value, output search_key,
                  input ready);
  modport sink (input valid, input mode, input new_value, input search_key,
                output ready);
endinterface

interface ole_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] item_value;
  logic [4:0]         item_index;
  logic [5:0]         list_length;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output item_value, output item_index,
                  output list_length, output status, output last, input ready);
  modport sink (input valid, input item_value, input item_index,
                input list_length, input status, input last, output ready);
endinterface

>>> rtl/ole_store.sv
// entry store: one write port, one read port with registered read data
module ole_store
  import ole_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/ordered_list_engine.sv
// top level of the ordered list engine: operation sequencer and result register
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   mode, new_value, search_key
//   out_ch   out  valid/ready   item_value, item_index, list_length, status, last
//
// entries sit packed from the front in a single-port-read, single-port-write store.
// a keyed operation first runs a key search (one read per cycle), a change to the list
// then shifts entries (read and write back one entry per cycle), and the results are
// read out through the store's read port one at a time, all paced by that one port.
// in_ch is ready only between operations; the final result may still wait in the
// output register while the next item is taken. a stalled out_ch holds the readout.
// rst empties the list at once; the store itself needs no clearing.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  ole_in_if.sink    in_ch,
  ole_out_if.source out_ch
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  mode_t            op_mode, op_mode_next;
  logic [VAL_W-1:0] op_val, op_val_next;
  logic [VAL_W-1:0] op_key, op_key_next;
  status_t          status, status_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             pend, pend_next;
  logic [CNT_W-1:0] pend_idx, pend_idx_next;
  logic             emit_pend, emit_pend_next;
  logic [CNT_W-1:0] emit_idx, emit_idx_next;
  logic             load_zero;

  logic              out_valid;
  logic [VAL_W-1:0]  out_value;
  logic [OIDX_W-1:0] out_index;
  logic [LEN_W-1:0]  out_length;
  status_t           out_status;
  logic              out_last;

  mem_req_t         req;
  logic [VAL_W-1:0] rdata;

  ole_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign in_ch.ready = (state == S_IDLE);

  // sequencer: decode, search, shift and readout
  always_comb begin
    state_next     = state;
    count_next     = count;
    op_mode_next   = op_mode;
    op_val_next    = op_val;
    op_key_next    = op_key;
    status_next    = status;
    pos_next       = pos;
    ptr_next       = ptr;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    emit_pend_next = 1'b0;
    emit_idx_next  = emit_idx;
    load_zero      = 1'b0;
    req            = '0;

    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_mode_next = mode_t'(in_ch.mode);
          op_val_next  = in_ch.new_value;
          op_key_next  = in_ch.search_key;
          status_next  = ST_OK;
          pend_next    = 1'b0;
          ptr_next     = '0;
          state_next   = S_EMIT;
          case (in_ch.mode) inside
            MD_INS_FRONT, MD_INS_BACK, MD_INS_AFTER, MD_INS_BEFORE: begin
              if (count == CNT_W'(CAPACITY)) begin
                status_next = ST_FULL;
              end else if (in_ch.mode == MD_INS_FRONT) begin
                pos_next   = '0;
                ptr_next   = count;
                state_next = S_SHIFT_UP;
              end else if (in_ch.mode == MD_INS_BACK) begin
                pos_next   = count;
                ptr_next   = count;
                state_next = S_SHIFT_UP;
              end else if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                state_next = S_SEARCH;
              end
            end
            MD_DEL_FRONT, MD_DEL_BACK, MD_DEL_KEY: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (in_ch.mode == MD_DEL_FRONT) begin
                pos_next   = '0;
                state_next = S_SHIFT_DN;
              end else if (in_ch.mode == MD_DEL_BACK) begin
                ptr_next   = count - CNT_W'(1);
                pos_next   = count - CNT_W'(1);
                state_next = S_SHIFT_DN;
              end else begin
                state_next = S_SEARCH;
              end
            end
            default: begin
              // unused mode: list is read out unchanged
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (pend && (rdata == op_key)) begin
          // first match from the front
          pend_next = 1'b0;
          case (op_mode)
            MD_INS_AFTER: begin
              pos_next   = pend_idx + CNT_W'(1);
              ptr_next   = count;
              state_next = S_SHIFT_UP;
            end
            MD_INS_BEFORE: begin
              pos_next   = pend_idx;
              ptr_next   = count;
              state_next = S_SHIFT_UP;
            end
            default: begin
              pos_next   = pend_idx;
              ptr_next   = pend_idx;
              state_next = S_SHIFT_DN;
            end
          endcase
        end else if (ptr < count) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = IDX_W'(ptr);
          pend_next     = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = ptr + CNT_W'(1);
        end else if (!pend) begin
          status_next = ST_NOKEY;
          ptr_next    = '0;
          state_next  = S_EMIT;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_SHIFT_UP: begin
        // move entries one place back, from the end down to the slot
        if (pend) begin
          req.wr_en   = 1'b1;
          req.wr_addr = IDX_W'(pend_idx);
          req.wr_data = rdata;
        end
        if (ptr > pos) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = IDX_W'(ptr - CNT_W'(1));
          pend_next     = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = ptr - CNT_W'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            req.wr_en   = 1'b1;
            req.wr_addr = IDX_W'(pos);
            req.wr_data = op_val;
            count_next  = count + CNT_W'(1);
            ptr_next    = '0;
            state_next  = S_EMIT;
          end
        end
      end

      S_SHIFT_DN: begin
        // move entries one place forward over the removed slot
        if (pend) begin
          req.wr_en   = 1'b1;
          req.wr_addr = IDX_W'(pend_idx);
          req.wr_data = rdata;
        end
        if ((ptr + CNT_W'(1)) < count) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = IDX_W'(ptr + CNT_W'(1));
          pend_next     = 1'b1;
          pend_idx_next = ptr;
          ptr_next      = ptr + CNT_W'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - CNT_W'(1);
            ptr_next   = '0;
            state_next = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        // one read per result, or the empty marker for an empty list, issued when the output register frees up
        if (!emit_pend && (!out_valid || out_ch.ready)) begin
          if (count == '0) begin
            load_zero  = 1'b1;
            state_next = S_IDLE;
          end else begin
            req.rd_en      = 1'b1;
            req.rd_addr    = IDX_W'(ptr);
            emit_pend_next = 1'b1;
            emit_idx_next  = ptr;
            ptr_next       = ptr + CNT_W'(1);
            if ((ptr + CNT_W'(1)) == count) begin
              state_next = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      emit_pend <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      emit_pend <= emit_pend_next;
    end
  end

  // operation and pointer registers
  always_ff @(posedge clk) begin
    op_mode  <= op_mode_next;
    op_val   <= op_val_next;
    op_key   <= op_key_next;
    status   <= status_next;
    pos      <= pos_next;
    ptr      <= ptr_next;
    pend_idx <= pend_idx_next;
    emit_idx <= emit_idx_next;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_pend || load_zero) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_pend) begin
      out_value  <= rdata;
      out_index  <= OIDX_W'(emit_idx);
      out_length <= LEN_W'(count);
      out_status <= status;
      out_last   <= ((emit_idx + CNT_W'(1)) == count);
    end else if (load_zero) begin
      out_value  <= '0;
      out_index  <= '0;
      out_length <= '0;
      out_status <= status;
      out_last   <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.item_value  = out_value;
  assign out_ch.item_index  = out_index;
  assign out_ch.list_length = out_length;
  assign out_ch.status      = out_status;
  assign out_ch.last        = out_last;

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the ordered list engine: directed table, random list traffic
module testbench
  import ole_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]         MD_UNUSED   = 3'd7;
  localparam logic signed [31:0] V_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] V_MAX       = 32'sh7fff_ffff;
  localparam int                 STALL_LIMIT = 5000;
  localparam int                 LONG_HOLD   = 150;
  localparam int                 TAIL_CYCLES = 300;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN} stim_phase_t;

  // one list operation; pinned rows carry a typed-in length and status
  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] val;
    logic signed [31:0] key;
    bit                 pinned;
    logic [5:0]         len;
    status_t            st;
  } list_op_t;

  // one entry of the readout that follows an operation
  typedef struct {
    logic signed [31:0] val;
    logic [4:0]         idx;
    logic [5:0]         len;
    status_t            st;
    logic               last;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ole_in_if  in_ch ();
  ole_out_if out_ch ();

  ordered_list_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the list and the readouts still owed by the block
  logic signed [31:0] shadow_entries [CAPACITY];
  int                 shadow_count = 0;
  readout_t           expected_readout [$];
  list_op_t           cur_op;
  int                 mismatch_count = 0;
  bit                 tx_idle_en = 1'b1;
  bit                 rx_idle_en = 1'b1;
  bit                 long_hold_req = 1'b0;
  int                 stall_cycles = 0;

  // directed table: empty-list errors, extremes, missing and duplicate keys, unused mode
  list_op_t directed_ops [0:23] = '{
    '{MD_DEL_FRONT,  32'sd0,        32'sd0,        1'b1, 6'd0, ST_EMPTY},
    '{MD_DEL_BACK,   32'sd0,        32'sd0,        1'b1, 6'd0, ST_EMPTY},
    '{MD_DEL_KEY,    32'sd0,        32'sd5,        1'b1, 6'd0, ST_EMPTY},
    '{MD_INS_AFTER,  32'sd9,        32'sd0,        1'b1, 6'd0, ST_EMPTY},
    '{MD_INS_BEFORE, 32'sd9,        32'sd0,        1'b1, 6'd0, ST_EMPTY},
    '{MD_UNUSED,     V_MAX,         V_MIN,         1'b1, 6'd0, ST_OK},
    '{MD_INS_BACK,   V_MAX,         32'sd0,        1'b1, 6'd1, ST_OK},
    '{MD_INS_FRONT,  V_MIN,         32'sd0,        1'b1, 6'd2, ST_OK},
    '{MD_INS_AFTER,  32'sd0,        V_MIN,         1'b1, 6'd3, ST_OK},
    '{MD_INS_BEFORE, -32'sd1,       V_MAX,         1'b1, 6'd4, ST_OK},
    '{MD_INS_AFTER,  32'sd3,        32'sd12345,    1'b1, 6'd4, ST_NOKEY},
    '{MD_DEL_KEY,    32'sd0,        32'sd777,      1'b1, 6'd4, ST_NOKEY},
    '{MD_INS_BACK,   32'sd0,        32'sd0,        1'b0, 6'd0, ST_OK},
    '{MD_INS_BEFORE, 32'sh5555_5555, 32'sd0,       1'b0, 6'd0, ST_OK},
    '{MD_DEL_KEY,    32'sd0,        32'sd0,        1'b0, 6'd0, ST_OK},
    '{MD_INS_AFTER,  32'shaaaa_aaaa, 32'sd0,       1'b0, 6'd0, ST_OK},
    '{MD_UNUSED,     -32'sd1,       -32'sd1,       1'b0, 6'd0, ST_OK},
    '{MD_DEL_FRONT,  32'sd0,        32'sd0,        1'b0, 6'd0, ST_OK},
    '{MD_DEL_BACK,   32'sd0,        32'sd0,        1'b0, 6'd0, ST_OK},
    '{MD_DEL_KEY,    32'sd0,        V_MAX,         1'b0, 6'd0, ST_OK},
    '{MD_DEL_KEY,    32'sd0,        -32'sd1,       1'b0, 6'd0, ST_OK},
    '{MD_DEL_BACK,   32'sd0,        32'sd0,        1'b1, 6'd1, ST_OK},
    '{MD_DEL_FRONT,  32'sd0,        32'sd0,        1'b1, 6'd0, ST_OK},
    '{MD_INS_FRONT,  -32'sd1,       -32'sd1,       1'b1, 6'd1, ST_OK}
  };

  // clock
  always begin
    #2 clk = ~clk;
  end

  // apply one operation to the shadow list and queue the readout it causes
  task automatic predict_readout(input list_op_t op);
    status_t  st;
    int       pos;
    int       i;
    readout_t r;
    st  = ST_OK;
    pos = -1;
    case (op.mode) inside
      MD_INS_FRONT, MD_INS_BACK, MD_INS_AFTER, MD_INS_BEFORE: begin
        if (shadow_count >= CAPACITY) begin
          st = ST_FULL;
        end else if (op.mode == MD_INS_FRONT) begin
          pos = 0;
        end else if (op.mode == MD_INS_BACK) begin
          pos = shadow_count;
        end else if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_entries[i] == op.key) pos = i;
          end
          if (pos < 0) st = ST_NOKEY;
          else if (op.mode == MD_INS_AFTER) pos = pos + 1;
        end
        // open a slot at pos
        if (st == ST_OK) begin
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = op.val;
          shadow_count++;
        end
      end
      MD_DEL_FRONT, MD_DEL_BACK, MD_DEL_KEY: begin
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else if (op.mode == MD_DEL_FRONT) begin
          pos = 0;
        end else if (op.mode == MD_DEL_BACK) begin
          pos = shadow_count - 1;
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_entries[i] == op.key) pos = i;
          end
          if (pos < 0) st = ST_NOKEY;
        end
        // close the slot at pos
        if (st == ST_OK) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase

    // readout: one entry per list position, or a single empty marker
    if (shadow_count == 0) begin
      r = '{32'sd0, 5'd0, 6'd0, st, 1'b1};
      if (op.pinned) begin
        r.len = op.len;
        r.st  = op.st;
      end
      expected_readout.push_back(r);
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        r.val  = shadow_entries[i];
        r.idx  = i[4:0];
        r.len  = shadow_count[5:0];
        r.st   = st;
        r.last = (i == shadow_count - 1);
        if (op.pinned) begin
          r.len = op.len;
          r.st  = op.st;
        end
        expected_readout.push_back(r);
      end
    end
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_readout();
    readout_t r;
    if (expected_readout.size() == 0) begin
      $error("unexpected result: item_value %0d item_index %0d", out_ch.item_value,
             out_ch.item_index);
      mismatch_count++;
    end else begin
      r = expected_readout.pop_front();
      if (out_ch.item_value !== r.val) begin
        $error("item_value: expected %0d, got %0d", r.val, out_ch.item_value);
        mismatch_count++;
      end
      if (out_ch.item_index !== r.idx) begin
        $error("item_index: expected %0d, got %0d", r.idx, out_ch.item_index);
        mismatch_count++;
      end
      if (out_ch.list_length !== r.len) begin
        $error("list_length: expected %0d, got %0d", r.len, out_ch.list_length);
        mismatch_count++;
      end
      if (out_ch.status !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, out_ch.status);
        mismatch_count++;
      end
      if (out_ch.last !== r.last) begin
        $error("last: expected %0d, got %0d", r.last, out_ch.last);
        mismatch_count++;
      end
    end
  endtask

  // results first, then the newly accepted item, at every rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_readout();
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) predict_readout(cur_op);
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $error("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: random short stalls and one long hold-off on request
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ch.ready = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst_left   = $urandom_range(1, 3) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // offer one item and hold it until it is taken
  task automatic offer(input list_op_t op);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cur_op           = op;
    in_ch.mode       = op.mode;
    in_ch.new_value  = op.val;
    in_ch.search_key = op.key;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // small pool for duplicates, extremes, or anything
  function automatic logic signed [31:0] pick_value();
    int                 sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom_range(0, 7);
      v = v - 32'sd3;
    end else if (sel == 4) begin
      v = $urandom_range(0, 1) ? V_MAX : V_MIN;
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  // mostly a key that is in the list, so keyed operations get past the search
  function automatic logic signed [31:0] pick_key();
    if (shadow_count > 0 && $urandom_range(0, 9) < 7)
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    return pick_value();
  endfunction

  // operation mix leans toward inserts while filling and deletes while draining
  function automatic logic [2:0] pick_mode(input stim_phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 30) return MD_INS_FRONT;
        if (r < 55) return MD_INS_BACK;
        if (r < 70) return MD_INS_AFTER;
        if (r < 85) return MD_INS_BEFORE;
        if (r < 89) return MD_DEL_FRONT;
        if (r < 93) return MD_DEL_BACK;
        if (r < 97) return MD_DEL_KEY;
        return MD_UNUSED;
      end
      PH_DRAIN: begin
        if (r < 8)  return MD_INS_FRONT;
        if (r < 14) return MD_INS_BACK;
        if (r < 19) return MD_INS_AFTER;
        if (r < 24) return MD_INS_BEFORE;
        if (r < 48) return MD_DEL_FRONT;
        if (r < 72) return MD_DEL_BACK;
        if (r < 97) return MD_DEL_KEY;
        return MD_UNUSED;
      end
      default: begin
        if (r >= 98) return MD_UNUSED;
        return 3'(r / 14);
      end
    endcase
  endfunction

  task automatic offer_random(input stim_phase_t ph);
    list_op_t op;
    op.mode   = pick_mode(ph);
    op.val    = pick_value();
    op.key    = pick_key();
    op.pinned = 1'b0;
    op.len    = 6'd0;
    op.st     = ST_OK;
    offer(op);
  endtask

  // stimulus and end of run
  initial begin
    int n;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MD_INS_FRONT;
    in_ch.new_value  = 32'sd0;
    in_ch.search_key = 32'sd0;
    cur_op           = directed_ops[0];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_ops[i]) offer(directed_ops[i]);

    // fill up to capacity, then keep pushing against a full list
    n = 0;
    while (shadow_count < CAPACITY && n < 300) begin
      offer_random(PH_FILL);
      n++;
    end
    repeat (8) offer_random(PH_FILL);

    // long result stall while items keep coming
    long_hold_req = 1'b1;
    repeat (60) offer_random(PH_MIX);

    // sender pause until every result has arrived
    in_ch.valid = 1'b0;
    while (expected_readout.size() != 0) @(negedge clk);

    // drain down to empty, then keep poking the empty list
    n = 0;
    while (shadow_count > 0 && n < 300) begin
      offer_random(PH_DRAIN);
      n++;
    end
    repeat (6) offer_random(PH_DRAIN);

    repeat (60) offer_random(PH_MIX);

    // final stretch at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (40) offer_random(PH_MIX);
    in_ch.valid = 1'b0;

    while (expected_readout.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
